/* hdl/bleaes_pkg.sv */
// ----------------------------------------------------------------------------
// bleaes_pkg
// Shared types and constants of the advertising event sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bleaes_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned PDU_TYPE_W = 4;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned RAND_W     = 32;
  localparam int unsigned ACTION_W   = 4;
  localparam int unsigned CHAN_W     = 6;
  localparam int unsigned TMO_W      = 8;
  localparam int unsigned DIST_W     = 25;
  localparam int unsigned US_W       = 24;
  localparam int unsigned EN_W       = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned DIV_CNT_W  = $clog2(RAND_W);

  localparam logic [CHAN_W-1:0]     CH_FIRST      = 6'd37;
  localparam logic [CHAN_W-1:0]     CH_SECOND     = 6'd38;
  localparam logic [CHAN_W-1:0]     CH_THIRD      = 6'd39;
  localparam logic [CHAN_W-1:0]     CH_END        = 6'd40;
  localparam logic [CHAN_W-1:0]     CH_BEFORE     = 6'd36;
  localparam logic [TMO_W-1:0]      LISTEN_US     = 8'd200;
  localparam logic [PDU_TYPE_W-1:0] SCAN_REQ_TYPE = 4'd3;
  localparam logic [LEN_W-1:0]      SCAN_REQ_LEN  = 6'd12;

  typedef enum logic [FUNC_W-1:0] {
    FN_START   = 3'd0,
    FN_STOP    = 3'd1,
    FN_SLOT    = 3'd2,
    FN_DONE    = 3'd3,
    FN_TIMEOUT = 3'd4
  } func_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE       = 4'd0,
    ACT_REQ_SLOT   = 4'd1,
    ACT_END_SLOT   = 4'd2,
    ACT_DISABLE    = 4'd3,
    ACT_SEND_ADV   = 4'd4,
    ACT_LISTEN     = 4'd5,
    ACT_SEND_RSP   = 4'd6,
    ACT_NEXT_END   = 4'd7,
    ACT_START_REJ  = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    STEP_SEND_ADV  = 2'd0,
    STEP_LISTEN    = 2'd1,
    STEP_CHECK_REQ = 2'd2,
    STEP_IDLE      = 2'd3
  } step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL  = 2'd0,
    CFG_MAX_DELAY = 2'd1,
    CFG_CHANNELS  = 2'd2,
    CFG_OWN_ADDR  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_step;
    logic commit;
  } bleaes_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } bleaes_status_t;

endpackage

`default_nettype wire

/* hdl/bleaes_if.sv */
// ----------------------------------------------------------------------------
// bleaes_in_if / bleaes_out_if
// Valid/ready channels carrying event beats in and action beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bleaes_in_if
  import bleaes_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic                  scannable;
  logic                  crc_ok;
  logic [PDU_TYPE_W-1:0] rx_pdu_type;
  logic [LEN_W-1:0]      rx_length;
  logic [ADDR_W-1:0]     rx_target_address;
  logic [RAND_W-1:0]     rand_value;

  modport source (
    output valid, func, scannable, crc_ok, rx_pdu_type, rx_length,
           rx_target_address, rand_value,
    input  ready
  );
  modport sink (
    input  valid, func, scannable, crc_ok, rx_pdu_type, rx_length,
           rx_target_address, rand_value,
    output ready
  );
endinterface

interface bleaes_out_if
  import bleaes_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAN_W-1:0]   channel;
  logic                listen_after;
  logic [TMO_W-1:0]    listen_tmo;
  logic [DIST_W-1:0]   next_distance_us;

  modport source (
    output valid, action, channel, listen_after, listen_tmo, next_distance_us,
    input  ready
  );
  modport sink (
    input  valid, action, channel, listen_after, listen_tmo, next_distance_us,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/bleaes_dp.sv */
// ----------------------------------------------------------------------------
// bleaes_dp
// Datapath: configuration and event state, input beat register, decision
// logic, bit-serial remainder unit and output beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module bleaes_dp
  import bleaes_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [FUNC_W-1:0]     func,
  input  wire logic                  scannable,
  input  wire logic                  crc_ok,
  input  wire logic [PDU_TYPE_W-1:0] rx_pdu_type,
  input  wire logic [LEN_W-1:0]      rx_length,
  input  wire logic [ADDR_W-1:0]     rx_target_address,
  input  wire logic [RAND_W-1:0]     rand_value,
  input  wire bleaes_cmd_t           cmd,
  output bleaes_status_t             status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ACTION_W-1:0]        action,
  output logic [CHAN_W-1:0]          channel,
  output logic                       listen_after,
  output logic [TMO_W-1:0]           listen_tmo,
  output logic [DIST_W-1:0]          next_distance_us
);

  // configuration
  logic [US_W-1:0]   adv_interval;
  logic [US_W-1:0]   delay_mod;
  logic [EN_W-1:0]   chan_en;
  logic [ADDR_W-1:0] own_addr;

  // event state
  step_t             step;
  logic [CHAN_W-1:0] cur_chan;
  logic              scan_latch;
  logic              adv_active;

  // captured beat
  logic [FUNC_W-1:0]     r_func;
  logic                  r_scannable;
  logic                  r_crc_ok;
  logic [PDU_TYPE_W-1:0] r_type;
  logic [LEN_W-1:0]      r_len;
  logic [ADDR_W-1:0]     r_target;
  logic [RAND_W-1:0]     r_rand;

  // remainder unit
  logic [RAND_W-1:0]    div_q;
  logic [US_W-1:0]      rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [US_W-1:0]      modulus;
  logic [US_W:0]        trial;
  logic [US_W:0]        trial_sub;

  // decision
  step_t             step_next;
  logic [CHAN_W-1:0] chan_next;
  logic              scan_latch_next;
  logic              adv_active_next;
  action_t           act_c;
  logic [CHAN_W-1:0] chan_c;
  logic              listen_c;
  logic [TMO_W-1:0]  tmo_c;
  logic              need_div_c;
  logic [CHAN_W-1:0] adv_chan;
  logic              scan_req_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      adv_interval <= '0;
      delay_mod    <= US_W'(1);
      chan_en      <= '1;
      own_addr     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERVAL:  adv_interval <= cfg_data[US_W-1:0];
        CFG_MAX_DELAY: delay_mod    <= cfg_data[US_W-1:0];
        CFG_CHANNELS:  chan_en      <= cfg_data[EN_W-1:0];
        CFG_OWN_ADDR:  own_addr     <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r_func      <= func;
      r_scannable <= scannable;
      r_crc_ok    <= crc_ok;
      r_type      <= rx_pdu_type;
      r_len       <= rx_length;
      r_target    <= rx_target_address;
      r_rand      <= rand_value;
    end
  end

  // next enabled channel after the current one
  always_comb begin
    if (cur_chan >= CH_END) begin
      adv_chan = CH_END;
    end else if (cur_chan < CH_FIRST && chan_en[0]) begin
      adv_chan = CH_FIRST;
    end else if (cur_chan < CH_SECOND && chan_en[1]) begin
      adv_chan = CH_SECOND;
    end else if (cur_chan < CH_THIRD && chan_en[2]) begin
      adv_chan = CH_THIRD;
    end else begin
      adv_chan = CH_END;
    end
  end

  assign scan_req_ok = r_crc_ok && (r_type == SCAN_REQ_TYPE) &&
                       (r_len == SCAN_REQ_LEN) && (r_target == own_addr);

  always_comb begin
    step_next       = step;
    chan_next       = cur_chan;
    scan_latch_next = scan_latch;
    adv_active_next = adv_active;
    act_c           = ACT_NONE;
    chan_c          = '0;
    listen_c        = 1'b0;
    tmo_c           = '0;
    need_div_c      = 1'b0;
    case (r_func)
      FN_START: begin
        if (adv_interval == '0) begin
          act_c = ACT_START_REJ;
        end else begin
          adv_active_next = 1'b1;
          act_c           = ACT_REQ_SLOT;
        end
      end
      FN_STOP: begin
        adv_active_next = 1'b0;
      end
      FN_SLOT: begin
        if (adv_active) begin
          scan_latch_next = r_scannable;
          chan_next       = CH_BEFORE;
          step_next       = STEP_SEND_ADV;
          act_c           = ACT_DISABLE;
        end else begin
          act_c = ACT_END_SLOT;
        end
      end
      FN_DONE: begin
        case (step)
          STEP_SEND_ADV: begin
            chan_next = adv_chan;
            if (adv_chan < CH_END) begin
              act_c     = ACT_SEND_ADV;
              chan_c    = adv_chan;
              listen_c  = scan_latch;
              step_next = scan_latch ? STEP_LISTEN : STEP_IDLE;
            end else if (adv_active) begin
              act_c      = ACT_NEXT_END;
              need_div_c = 1'b1;
            end else begin
              act_c = ACT_END_SLOT;
            end
          end
          STEP_LISTEN: begin
            act_c     = ACT_LISTEN;
            tmo_c     = LISTEN_US;
            step_next = STEP_CHECK_REQ;
          end
          STEP_CHECK_REQ: begin
            if (scan_req_ok) begin
              act_c     = ACT_SEND_RSP;
              step_next = STEP_IDLE;
            end else begin
              act_c     = ACT_DISABLE;
              step_next = STEP_SEND_ADV;
            end
          end
          default: begin
            act_c     = ACT_DISABLE;
            step_next = STEP_SEND_ADV;
          end
        endcase
      end
      FN_TIMEOUT: begin
        if (step == STEP_CHECK_REQ) begin
          act_c     = ACT_DISABLE;
          step_next = STEP_SEND_ADV;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_SEND_ADV;
      cur_chan   <= CH_BEFORE;
      scan_latch <= 1'b0;
      adv_active <= 1'b0;
    end else if (cmd.commit) begin
      step       <= step_next;
      cur_chan   <= chan_next;
      scan_latch <= scan_latch_next;
      adv_active <= adv_active_next;
    end
  end

  // restoring remainder, one dividend bit per cycle
  assign modulus   = (delay_mod == '0) ? US_W'(1) : delay_mod;
  assign trial     = {rem, div_q[RAND_W-1]};
  assign trial_sub = trial - {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= r_rand;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_q   <= {div_q[RAND_W-2:0], 1'b0};
      rem     <= (trial >= {1'b0, modulus}) ? trial_sub[US_W-1:0] : trial[US_W-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  assign status.need_div = need_div_c;
  assign status.div_last = (div_cnt == DIV_CNT_W'(RAND_W - 1));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      action           <= act_c;
      channel          <= chan_c;
      listen_after     <= listen_c;
      listen_tmo       <= tmo_c;
      next_distance_us <= need_div_c ?
                          ({1'b0, adv_interval} + {1'b0, rem}) : '0;
    end
  end

endmodule

`default_nettype wire

/* hdl/bleaes_ctrl.sv */
// ----------------------------------------------------------------------------
// bleaes_ctrl
// Controller: sequences beat capture, the serial remainder and the commit
// of each result into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bleaes_ctrl
  import bleaes_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bleaes_status_t status,
  output bleaes_cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ble_advertising_event_sequencer_core.sv */
// Flow: an accepted beat is captured in the input register, evaluated and
// committed to the output register once it is free; a request-next-and-end
// result first runs the bit-serial remainder. A new beat is taken only after the
// last one is committed; the output register lets a result wait while the next beat enters.
// Reset: synchronous, active high; clears state, configuration and output valid.
// ----------------------------------------------------------------------------
// ble_advertising_event_sequencer_core
// Top level: advertising event sequencer, controller plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_advertising_event_sequencer_core
  import bleaes_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  bleaes_in_if.sink                  in_ch,
  bleaes_out_if.source               out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  bleaes_cmd_t    cmd;
  bleaes_status_t status;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  bleaes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bleaes_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .func              (in_ch.func),
    .scannable         (in_ch.scannable),
    .crc_ok            (in_ch.crc_ok),
    .rx_pdu_type       (in_ch.rx_pdu_type),
    .rx_length         (in_ch.rx_length),
    .rx_target_address (in_ch.rx_target_address),
    .rand_value        (in_ch.rand_value),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .action            (out_ch.action),
    .channel           (out_ch.channel),
    .listen_after      (out_ch.listen_after),
    .listen_tmo        (out_ch.listen_tmo),
    .next_distance_us  (out_ch.next_distance_us)
  );

endmodule

`default_nettype wire

/* hdl/bleaes_chk.sv */
// ----------------------------------------------------------------------------
// bleaes_chk
// Port-level checks on the sequencer top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bleaes_chk
  import bleaes_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [ACTION_W-1:0] action,
  input wire logic [DIST_W-1:0]   next_distance_us
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid after reset");

  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while one is in flight");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(action) && $stable(next_distance_us)))
    else $error("output beat changed while stalled");

endmodule

bind ble_advertising_event_sequencer_core bleaes_chk u_bleaes_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .action           (out_ch.action),
  .next_distance_us (out_ch.next_distance_us)
);

`default_nettype wire
